[sv/ipe_pkg.sv]
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared types and constants of the IP payload eraser: beat layouts, the
// command word passed from the classifier to the output stage, and the
// protocol numbers and header offsets that the classifier uses.
// ----------------------------------------------------------------------------
package ipe_pkg;

  // Width of the saturating byte position counter within a packet.
  localparam int unsigned POSITION_BITS = 16;

  // Sums of up to 255 + 60 + 60 need nine bits; the width is at least ten.
  localparam int unsigned CMP_BITS = (POSITION_BITS >= 10) ? POSITION_BITS + 1 : 10;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int unsigned TCP_CKSUM_END = 18;
  localparam int unsigned UDP_HDR_LEN   = 8;
  localparam int unsigned CKSUM_LEN     = 2;

  // Offset of the protocol byte within the IPv4 header.
  localparam int unsigned IP_PROTO_OFS  = 9;
  // Offset of the data offset byte within the TCP header.
  localparam int unsigned TCP_DOFS_OFS  = 12;
  // Smallest header length in 32-bit words.
  localparam logic [3:0]  MIN_WORDS     = 4'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic [7:0] ip_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
    logic       discard;
  } out_beat_t;

  // A single beat is sent as given; a pair is two zero bytes, the second of
  // which carries the last and discard flags of the beat.
  typedef enum logic {
    CMD_SINGLE,
    CMD_PAIR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    out_beat_t beat;
  } cmd_t;

endpackage

[sv/ipe_front.sv]
// ----------------------------------------------------------------------------
// ipe_front
// Packet parser: tracks the byte position, captures the IPv4 header length,
// the protocol and the TCP data offset, and turns each accepted byte into
// an output command, or holds it back when it is the first checksum byte.
// ----------------------------------------------------------------------------
module ipe_front import ipe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t in_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]               hs_q, hs_d;
  logic [3:0]               hw_q, hw_d;
  logic [7:0]               proto_q, proto_d;
  logic                     seen_q, seen_d;
  logic [3:0]               tcpoff_q, tcpoff_d;
  logic                     held_q, held_d;

  logic [CMP_BITS-1:0] posw, hsw, tp, erase_from, ck_first;
  logic                is_tcp, is_udp, known, disc, erase_kind, hold;
  logic [7:0]          ob;

  // Header lengths below five words count as five.
  function automatic logic [3:0] clamp_words(input logic [3:0] w);
    return (w < MIN_WORDS) ? MIN_WORDS : w;
  endfunction

  // Header field capture, using the values this byte itself sets.
  always_comb begin
    posw    = CMP_BITS'(pos_q);
    hs_d    = (pos_q == '0) ? in_i.ip_start : hs_q;
    hsw     = CMP_BITS'(hs_d);
    hw_d    = (posw == hsw) ? clamp_words(in_i.data_byte[3:0]) : hw_q;
    proto_d = proto_q;
    seen_d  = seen_q;
    if (posw == hsw + CMP_BITS'(IP_PROTO_OFS)) begin
      proto_d = in_i.data_byte;
      seen_d  = 1'b1;
    end
    tp     = hsw + CMP_BITS'({hw_d, 2'b00});
    is_tcp = seen_d && (proto_d == PROTO_TCP);
    is_udp = seen_d && (proto_d == PROTO_UDP);
    known  = is_tcp || is_udp || (seen_d && (proto_d == PROTO_ICMP));
    disc   = !known;
    tcpoff_d = tcpoff_q;
    if (is_tcp && (posw == tp + CMP_BITS'(TCP_DOFS_OFS))) begin
      tcpoff_d = clamp_words(in_i.data_byte[7:4]);
    end
  end

  // Erase and checksum boundaries for this byte.
  always_comb begin
    if (is_tcp) begin
      erase_from = tp + CMP_BITS'({tcpoff_d, 2'b00});
      ck_first   = tp + CMP_BITS'(TCP_CKSUM_END - CKSUM_LEN);
    end else begin
      erase_from = tp + CMP_BITS'(UDP_HDR_LEN);
      ck_first   = tp + CMP_BITS'(UDP_HDR_LEN - CKSUM_LEN);
    end
    erase_kind = is_tcp || is_udp;
    hold       = !held_q && erase_kind && (posw == ck_first) && !in_i.end_of_packet;
    ob         = (erase_kind && (posw >= erase_from)) ? 8'h00 : in_i.data_byte;
  end

  // Command for the output stage.
  always_comb begin
    cmd_o.beat.last_out = in_i.end_of_packet;
    cmd_o.beat.discard  = in_i.end_of_packet && disc;
    if (held_q) begin
      cmd_o.kind          = CMD_PAIR;
      cmd_o.beat.byte_out = 8'h00;
    end else begin
      cmd_o.kind          = CMD_SINGLE;
      cmd_o.beat.byte_out = ob;
    end
    cmd_push_o = accept_i && !hold;
    held_d     = hold;
    pos_d      = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
  end

  // Per-packet state; everything returns to its reset value after a last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hs_q     <= '0;
      hw_q     <= MIN_WORDS;
      proto_q  <= '0;
      seen_q   <= 1'b0;
      tcpoff_q <= MIN_WORDS;
      held_q   <= 1'b0;
    end else if (accept_i) begin
      if (in_i.end_of_packet) begin
        pos_q    <= '0;
        hs_q     <= '0;
        hw_q     <= MIN_WORDS;
        proto_q  <= '0;
        seen_q   <= 1'b0;
        tcpoff_q <= MIN_WORDS;
        held_q   <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        hs_q     <= hs_d;
        hw_q     <= hw_d;
        proto_q  <= proto_d;
        seen_q   <= seen_d;
        tcpoff_q <= tcpoff_d;
        held_q   <= held_d;
      end
    end
  end

endmodule

[sv/ipe_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// ipe_cmd_fifo
// Two-entry command queue between the parser and the output stage, so that
// each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module ipe_cmd_fifo import ipe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/ipe_back.sv]
// ----------------------------------------------------------------------------
// ipe_back
// Output stage: expands commands into output beats and holds the oldest
// beat in a register until it is popped. A pair command yields two beats.
// ----------------------------------------------------------------------------
module ipe_back import ipe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_beat_t out_o
);

  logic      out_valid_q;
  out_beat_t out_q;
  logic      pend_q;
  out_beat_t pend_beat_q;
  logic      load;

  assign load      = !out_valid_q || pop_i;
  assign cmd_pop_o = load && !pend_q && !cmd_empty_i;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  // Output register and the pending second beat of a pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (!cmd_empty_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= (cmd_i.kind == CMD_PAIR);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat payload; the first beat of a pair is a plain zero byte.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_q <= pend_beat_q;
      end else if (!cmd_empty_i) begin
        unique case (cmd_i.kind)
          CMD_PAIR: begin
            out_q       <= '0;
            pend_beat_q <= cmd_i.beat;
          end
          CMD_SINGLE: begin
            out_q <= cmd_i.beat;
          end
          default: begin
            out_q <= cmd_i.beat;
          end
        endcase
      end
    end
  end

endmodule

[sv/ip_payload_eraser.sv]
// ----------------------------------------------------------------------------
// ip_payload_eraser
// Zeroes the transport payload and checksum of IPv4 TCP and UDP packets
// carried as a byte stream, and marks unknown protocols for discard.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     push / full          in_i  : data_byte, end_of_packet, ip_start
//  result    empty / pop          out_o : byte_out, last_out, discard
//
//  One byte is accepted per cycle while full is low. A result passes through
//  the command queue and the output register; the held first checksum byte
//  yields no result and is released with the next byte as two beats.
// Parser and output stage are parted by a two-entry command queue; full
// rises only when that queue is full, so a stalled pop backs up after two
// commands plus the output register. Reset clears all control state at once.
// ----------------------------------------------------------------------------
module ip_payload_eraser import ipe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_beat_t  in_i,
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_o
);

  logic accept;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Parser front end.
  ipe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue.
  ipe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out)
  );

  // Output stage.
  ipe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

[bench/tb_ip_payload_eraser.sv]
// ----------------------------------------------------------------------------
// tb_ip_payload_eraser
// Self-checking bench for the IP payload eraser. A short table of directed
// packets (single byte, cut-short, ICMP, unknown protocol) comes first. Then
// random TCP, UDP, ICMP, unknown and truncated packets follow. A behavioral
// model of the eraser predicts each beat that no typed table row gives, and
// each popped beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ip_payload_eraser;
  import ipe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_N        = 24;

  typedef enum int {
    KIND_TCP,
    KIND_UDP,
    KIND_ICMP,
    KIND_OTHER,
    KIND_SHORT
  } pkt_kind_e;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } row_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      full;
  in_beat_t  in_i   = '0;
  logic      empty;
  logic      pop    = 1'b0;
  out_beat_t out_o;

  // Stimulus control shared between processes.
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  // Scoreboard.
  out_beat_t awaited_beats [$];
  out_beat_t step_beats [2];
  int        mismatches   = 0;
  int        beats_in     = 0;
  int        beats_out    = 0;
  int        stall_cycles = 0;
  int        kind_count [5];

  // Eraser model state, one packet at a time.
  logic [15:0] pos_q;
  logic [7:0]  hdr_start_q;
  logic [3:0]  hdr_words_q;
  logic [7:0]  proto_q;
  logic        proto_seen_q;
  logic [3:0]  tcp_words_q;
  logic [7:0]  held_byte_q;
  logic        held_valid_q;

  ip_payload_eraser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Return the model to its idle packet state.
  function automatic void clear_packet();
    pos_q        = '0;
    hdr_start_q  = '0;
    hdr_words_q  = MIN_WORDS;
    proto_q      = '0;
    proto_seen_q = 1'b0;
    tcp_words_q  = MIN_WORDS;
    held_byte_q  = '0;
    held_valid_q = 1'b0;
  endfunction

  // Advance the model by one input byte; the beats it releases land in
  // step_beats and their number is returned.
  function automatic int erase_byte(input in_beat_t b);
    int        p;
    int        tp;
    int        erase_from;
    int        ck_first;
    int        n;
    logic      is_tcp;
    logic      is_udp;
    logic      drop;
    out_beat_t ob;
    p = pos_q;
    n = 0;
    if (p == 0) hdr_start_q = b.ip_start;
    if (p == int'(hdr_start_q)) begin
      hdr_words_q = (b.data_byte[3:0] < MIN_WORDS) ? MIN_WORDS : b.data_byte[3:0];
    end
    if (p == int'(hdr_start_q) + IP_PROTO_OFS) begin
      proto_q      = b.data_byte;
      proto_seen_q = 1'b1;
    end
    tp     = int'(hdr_start_q) + 4 * int'(hdr_words_q);
    is_tcp = proto_seen_q && proto_q == PROTO_TCP;
    is_udp = proto_seen_q && proto_q == PROTO_UDP;
    drop   = !(is_tcp || is_udp || (proto_seen_q && proto_q == PROTO_ICMP));
    if (is_tcp && p == tp + TCP_DOFS_OFS) begin
      tcp_words_q = (b.data_byte[7:4] < MIN_WORDS) ? MIN_WORDS : b.data_byte[7:4];
    end
    if (is_tcp) begin
      erase_from = tp + 4 * int'(tcp_words_q);
      ck_first   = tp + TCP_CKSUM_END - CKSUM_LEN;
    end else begin
      erase_from = tp + UDP_HDR_LEN;
      ck_first   = tp + UDP_HDR_LEN - CKSUM_LEN;
    end

    if (held_valid_q) begin
      // The checksum is complete, so both of its bytes leave as zero.
      step_beats[0] = '{byte_out: 8'h00, last_out: 1'b0, discard: 1'b0};
      step_beats[1] = '{byte_out: 8'h00, last_out: b.end_of_packet,
                        discard: b.end_of_packet && drop};
      n = 2;
      held_valid_q = 1'b0;
      held_byte_q  = '0;
    end else if ((is_tcp || is_udp) && p == ck_first && !b.end_of_packet) begin
      held_byte_q  = b.data_byte;
      held_valid_q = 1'b1;
    end else begin
      ob.byte_out = ((is_tcp || is_udp) && p >= erase_from) ? 8'h00 : b.data_byte;
      ob.last_out = b.end_of_packet;
      ob.discard  = b.end_of_packet && drop;
      step_beats[0] = ob;
      n = 1;
    end

    if (b.end_of_packet) begin
      clear_packet();
    end else if (pos_q != 16'hFFFF) begin
      pos_q = pos_q + 16'd1;
    end
    return n;
  endfunction

  function automatic row_t mk_row(input logic [7:0] d, input logic e, input logic [7:0] s,
                                  input logic t, input logic [7:0] wb, input logic wl,
                                  input logic wd);
    row_t r;
    r.beat  = '{data_byte: d, end_of_packet: e, ip_start: s};
    r.typed = t;
    r.want  = '{byte_out: wb, last_out: wl, discard: wd};
    return r;
  endfunction

  // Offer one beat until the block takes it, then record what it should emit.
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    int n;
    while (!calm && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_in++;
    n = erase_byte(b);
    if (typed) begin
      awaited_beats.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) awaited_beats.push_back(step_beats[k]);
    end
  endtask

  // Build a packet of the given kind with random content and send it.
  // A nonzero force_len fixes the packet length.
  task automatic send_packet(input pkt_kind_e kind, input int force_len);
    logic [7:0] pkt [$];
    int         ip_ofs;
    int         hw;
    int         dw;
    int         tp;
    int         len;
    int         sel;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] proto;
    in_beat_t   b;
    ip_ofs = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(12);
    if (force_len != 0) ip_ofs = $urandom_range(12);
    ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : MIN_WORDS;
    doff = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : MIN_WORDS;
    hw   = (ihl < MIN_WORDS) ? int'(MIN_WORDS) : int'(ihl);
    dw   = (doff < MIN_WORDS) ? int'(MIN_WORDS) : int'(doff);
    tp   = ip_ofs + 4 * hw;
    sel  = $urandom_range(5);
    proto = 8'h00;

    // Lengths lean toward the checksum boundaries: ending on the first
    // checksum byte, right after the checksum, and before it.
    case (kind)
      KIND_TCP: begin
        proto = PROTO_TCP;
        case (sel)
          0:       len = tp + TCP_CKSUM_END - 1;
          1:       len = tp + TCP_CKSUM_END;
          2:       len = tp + $urandom_range(TCP_CKSUM_END - 2);
          default: len = tp + 4 * dw + $urandom_range(12);
        endcase
      end
      KIND_UDP: begin
        proto = PROTO_UDP;
        case (sel)
          0:       len = tp + UDP_HDR_LEN - 1;
          1:       len = tp + UDP_HDR_LEN;
          2:       len = tp + $urandom_range(UDP_HDR_LEN - 2);
          default: len = tp + UDP_HDR_LEN + $urandom_range(16);
        endcase
      end
      KIND_ICMP: begin
        proto = PROTO_ICMP;
        len   = ip_ofs + IP_PROTO_OFS + 1 + $urandom_range(30);
      end
      KIND_OTHER: begin
        do begin
          proto = 8'($urandom_range(255));
        end while (proto == PROTO_ICMP || proto == PROTO_TCP || proto == PROTO_UDP);
        len = ip_ofs + IP_PROTO_OFS + 1 + $urandom_range(30);
      end
      default: begin
        // Ends before the protocol byte.
        len = 1 + $urandom_range(ip_ofs + IP_PROTO_OFS - 1);
      end
    endcase
    if (force_len != 0) len = force_len;

    for (int i = 0; i < len; i++) pkt.push_back(8'($urandom_range(255)));
    if (ip_ofs < len) pkt[ip_ofs] = {4'($urandom_range(15)), ihl};
    if (kind != KIND_SHORT && ip_ofs + IP_PROTO_OFS < len) pkt[ip_ofs + IP_PROTO_OFS] = proto;
    if (kind == KIND_TCP && tp + TCP_DOFS_OFS < len) begin
      pkt[tp + TCP_DOFS_OFS] = {doff, 4'($urandom_range(15))};
    end
    kind_count[kind]++;

    for (int i = 0; i < len; i++) begin
      b.data_byte     = pkt[i];
      b.end_of_packet = (i == len - 1);
      b.ip_start      = (i == 0) ? 8'(ip_ofs) : 8'($urandom_range(255));
      send_beat(b, 1'b0, '0);
    end
  endtask

  // Result side: random pops, one long hold-off on request, none while calm.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  // Compare every popped beat with the oldest prediction.
  always @(posedge clk_i) begin : checker_blk
    out_beat_t want;
    if (rst_ni && pop && !empty) begin
      beats_out++;
      if (awaited_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected beat: byte %02h last %b discard %b",
                   $realtime, out_o.byte_out, out_o.last_out, out_o.discard);
        end
      end else begin
        want = awaited_beats.pop_front();
        if (out_o.byte_out !== want.byte_out || out_o.last_out !== want.last_out ||
            out_o.discard !== want.discard) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] beat %0d: expected byte %02h last %b discard %b, got %02h %b %b",
                     $realtime, beats_out, want.byte_out, want.last_out, want.discard,
                     out_o.byte_out, out_o.last_out, out_o.discard);
          end
        end
      end
    end
  end

  // End the run if the block stops making progress while work is pending.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !(push || awaited_beats.size() != 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles, %0d beats still awaited",
               STALL_LIMIT, awaited_beats.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t dir_rows [DIR_N];
    int   pk;
    clear_packet();
    foreach (kind_count[k]) kind_count[k] = 0;

    // Directed packets: a single byte at the extremes, a packet cut short
    // after two bytes, ICMP with a header length below five words ending on
    // its protocol byte, and an unknown protocol with a 15-word header.
    dir_rows = '{
      mk_row(8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1),
      mk_row(8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0),
      mk_row(8'hA5, 1'b1, 8'hFF, 1'b1, 8'hA5, 1'b1, 1'b1),
      mk_row(8'h40, 1'b0, 8'h00, 1'b1, 8'h40, 1'b0, 1'b0),
      mk_row(8'h00, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0),
      mk_row(8'hFF, 1'b0, 8'h55, 1'b1, 8'hFF, 1'b0, 1'b0),
      mk_row(8'h12, 1'b0, 8'hAA, 1'b1, 8'h12, 1'b0, 1'b0),
      mk_row(8'h34, 1'b0, 8'h0F, 1'b1, 8'h34, 1'b0, 1'b0),
      mk_row(8'h56, 1'b0, 8'hF0, 1'b1, 8'h56, 1'b0, 1'b0),
      mk_row(8'h78, 1'b0, 8'h00, 1'b1, 8'h78, 1'b0, 1'b0),
      mk_row(8'h9A, 1'b0, 8'hFF, 1'b1, 8'h9A, 1'b0, 1'b0),
      mk_row(8'hBC, 1'b0, 8'h33, 1'b1, 8'hBC, 1'b0, 1'b0),
      mk_row(8'h01, 1'b1, 8'hCC, 1'b1, 8'h01, 1'b1, 1'b0),
      mk_row(8'h11, 1'b0, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h4F, 1'b0, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h80, 1'b0, 8'h7F, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'hFF, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h21, 1'b0, 8'h10, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h43, 1'b0, 8'h20, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h65, 1'b0, 8'h40, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'h87, 1'b0, 8'h08, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'hA9, 1'b0, 8'h04, 1'b0, 8'h00, 1'b0, 1'b0),
      mk_row(8'hFF, 1'b1, 8'h02, 1'b0, 8'h00, 1'b0, 1'b0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random packets: every kind once up front, then a weighted mix. One
    // stretch runs without idling, and one packet starts a long pop hold-off.
    pk = 0;
    while (beats_in < DIR_N + RANDOM_ITEMS) begin
      int r;
      pkt_kind_e kind;
      calm = (pk >= 8 && pk < 14);
      if (pk == 3) hold_req = 1'b1;
      r = $urandom_range(99);
      if (pk < 5)       kind = pkt_kind_e'(pk);
      else if (r < 35)  kind = KIND_TCP;
      else if (r < 65)  kind = KIND_UDP;
      else if (r < 75)  kind = KIND_ICMP;
      else if (r < 87)  kind = KIND_OTHER;
      else              kind = KIND_SHORT;
      send_packet(kind, 0);
      pk++;
    end
    calm = 1'b0;
    push <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d random packets: %0d TCP, %0d UDP, %0d ICMP,",
             beats_in, pk, kind_count[KIND_TCP], kind_count[KIND_UDP],
             kind_count[KIND_ICMP]);
    $display("%0d unknown, %0d cut short; checked %0d output beats, %0d mismatches",
             kind_count[KIND_OTHER], kind_count[KIND_SHORT], beats_out, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
